// ===== sv/sitbd_pkg.sv =====
// Package for the signed integer to base digits converter.
// Holds widths, the alphabet reset words, microcode types and the control store.
// No dependencies.
package sitbd_pkg;

  localparam int unsigned MAX_BASE_DEF = 32;
  localparam int unsigned ALPHA_WORDS  = 4;
  localparam int unsigned WORD_W       = 64;
  localparam int unsigned ALPHA_BYTES  = 32;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned ALPHA_W      = ALPHA_BYTES * CHAR_W;
  localparam int unsigned AIDX_W       = $clog2(ALPHA_BYTES);
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned DIGIT_IDX_W  = $clog2(ALPHA_BYTES);
  localparam int unsigned DIGIT_CNT_W  = DIGIT_IDX_W + 1;
  localparam int unsigned DIV_BITS     = 8;
  localparam int unsigned DIV_STEPS    = VALUE_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;

  localparam logic [WORD_W-1:0] ALPHA_RESET [ALPHA_WORDS] = '{
    64'h3736_3534_3332_3130,
    64'h0000_0000_0000_3938,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA0 = 3'd0,
    REG_ALPHA1 = 3'd1,
    REG_ALPHA2 = 3'd2,
    REG_ALPHA3 = 3'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_SCAN,
    OP_CLRI,
    OP_NOP,
    OP_INCI,
    OP_DIVINIT,
    OP_DIV,
    OP_STORE,
    OP_SIGN,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_SCAN_MORE,
    C_LEN_SHORT,
    C_BAD_CHAR,
    C_CHECK_MORE,
    C_DIV_MORE,
    C_DIGIT_MORE,
    C_EMIT_MORE
  } cond_t;

  typedef enum logic [3:0] {
    PC_IDLE,
    PC_SCAN,
    PC_LENCHK,
    PC_CHECK,
    PC_NEXTI,
    PC_DIVINIT,
    PC_DIV,
    PC_STORE,
    PC_SIGN,
    PC_EMIT,
    PC_DONE
  } pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic scan_more;
    logic len_short;
    logic bad_char;
    logic check_more;
    logic div_more;
    logic digit_more;
    logic emit_more;
  } dp_status_t;

  function automatic ctrl_word_t ucode_rom(input pc_t pc);
    ctrl_word_t w;
    unique case (pc)
      PC_IDLE:    w = '{OP_LOAD,    C_NO_START,   PC_IDLE};
      PC_SCAN:    w = '{OP_SCAN,    C_SCAN_MORE,  PC_SCAN};
      PC_LENCHK:  w = '{OP_CLRI,    C_LEN_SHORT,  PC_IDLE};
      PC_CHECK:   w = '{OP_NOP,     C_BAD_CHAR,   PC_IDLE};
      PC_NEXTI:   w = '{OP_INCI,    C_CHECK_MORE, PC_CHECK};
      PC_DIVINIT: w = '{OP_DIVINIT, C_NEVER,      PC_IDLE};
      PC_DIV:     w = '{OP_DIV,     C_DIV_MORE,   PC_DIV};
      PC_STORE:   w = '{OP_STORE,   C_DIGIT_MORE, PC_DIVINIT};
      PC_SIGN:    w = '{OP_SIGN,    C_NEVER,      PC_IDLE};
      PC_EMIT:    w = '{OP_EMIT,    C_EMIT_MORE,  PC_EMIT};
      PC_DONE:    w = '{OP_NOP,     C_ALWAYS,     PC_IDLE};
      default:    w = '{OP_NOP,     C_ALWAYS,     PC_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] a,
                                                   input logic [AIDX_W-1:0] k);
    return a[{k, 3'b000} +: CHAR_W];
  endfunction

endpackage

// ===== sv/sitbd_cfg.sv =====
// Configuration registers holding the four alphabet words.
// Depends on sitbd_pkg.
module sitbd_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [sitbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sitbd_pkg::WORD_W-1:0]      cfg_data,
  output logic [sitbd_pkg::ALPHA_W-1:0]     alpha
);
  import sitbd_pkg::*;

  logic [WORD_W-1:0] word_r   [ALPHA_WORDS];
  logic [WORD_W-1:0] word_nxt [ALPHA_WORDS];

  always_comb begin
    for (int w = 0; w < ALPHA_WORDS; w++) begin
      word_nxt[w] = word_r[w];
    end
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ALPHA0: word_nxt[0] = cfg_data;
        REG_ALPHA1: word_nxt[1] = cfg_data;
        REG_ALPHA2: word_nxt[2] = cfg_data;
        REG_ALPHA3: word_nxt[3] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < ALPHA_WORDS; w++) begin
      if (!rst_n) begin
        word_r[w] <= ALPHA_RESET[w];
      end else begin
        word_r[w] <= word_nxt[w];
      end
    end
  end

  assign alpha = {word_r[3], word_r[2], word_r[1], word_r[0]};

endmodule

// ===== sv/sitbd_useq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on sitbd_pkg.
module sitbd_useq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  sitbd_pkg::dp_status_t   status,
  output sitbd_pkg::ctrl_word_t   ctrl,
  output logic                    busy
);
  import sitbd_pkg::*;

  pc_t  pc_r;
  pc_t  pc_nxt;
  logic take;

  assign ctrl = ucode_rom(pc_r);
  assign busy = (pc_r != PC_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_START:   take = !start;
      C_SCAN_MORE:  take = status.scan_more;
      C_LEN_SHORT:  take = status.len_short;
      C_BAD_CHAR:   take = status.bad_char;
      C_CHECK_MORE: take = status.check_more;
      C_DIV_MORE:   take = status.div_more;
      C_DIGIT_MORE: take = status.digit_more;
      C_EMIT_MORE:  take = status.emit_more;
      default:      take = 1'b1;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_t'(pc_r + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== sv/sitbd_dp.sv =====
// Datapath: alphabet scan and check, shared radix divider, digit buffer, output register.
// Depends on sitbd_pkg; driven by the control words of sitbd_useq.
module sitbd_dp #(
  parameter int unsigned MAX_BASE = sitbd_pkg::MAX_BASE_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sitbd_pkg::ctrl_word_t              ctrl,
  input  logic signed [sitbd_pkg::VALUE_W-1:0] in_value,
  input  logic [sitbd_pkg::ALPHA_W-1:0]      alpha,
  output sitbd_pkg::dp_status_t              status,
  output logic                               out_strobe,
  output logic [sitbd_pkg::CHAR_W-1:0]       out_character,
  output logic                               out_last
);
  import sitbd_pkg::*;

  localparam int unsigned KW = $clog2(MAX_BASE + 1);
  localparam int unsigned RW = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;

  logic [KW-1:0]          k_r, k_nxt;
  logic [KW-1:0]          i_r, i_nxt;
  logic                   neg_r, neg_nxt;
  logic [VALUE_W-1:0]     dq_r, dq_nxt;
  logic [RW-1:0]          rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIGIT_CNT_W-1:0] nd_r, nd_nxt;
  logic [CHAR_W-1:0]      digit_r [ALPHA_BYTES];
  logic                   out_strobe_r, out_strobe_nxt;
  logic [CHAR_W-1:0]      out_character_r, out_character_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [VALUE_W-1:0]     v_u;
  logic [VALUE_W-1:0]     mag;
  logic [CHAR_W-1:0]      char_k;
  logic [CHAR_W-1:0]      char_i;
  logic                   dup;
  logic [RW-1:0]          div_rem;
  logic [VALUE_W-1:0]     div_q;
  logic [RW:0]            div_acc;
  logic [DIGIT_IDX_W-1:0] rd_idx;

  assign v_u    = in_value;
  assign mag    = v_u[VALUE_W-1] ? (~v_u + 32'd1) : v_u;
  assign char_k = alpha_char(alpha, AIDX_W'(k_r));
  assign char_i = alpha_char(alpha, AIDX_W'(i_r));
  assign rd_idx = DIGIT_IDX_W'(nd_r - 1'b1);

  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_BASE; j++) begin
      if ((KW'(j) > i_r) && (KW'(j) < k_r) &&
          (alpha_char(alpha, AIDX_W'(j)) == char_i)) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    div_rem = rem_r;
    div_q   = dq_r;
    div_acc = '0;
    for (int s = 0; s < DIV_BITS; s++) begin
      div_acc = {div_rem, div_q[VALUE_W-1]};
      div_q   = {div_q[VALUE_W-2:0], 1'b0};
      if (div_acc >= (RW+1)'(k_r)) begin
        div_acc  = div_acc - (RW+1)'(k_r);
        div_q[0] = 1'b1;
      end
      div_rem = div_acc[RW-1:0];
    end
  end

  always_comb begin
    status.scan_more  = (k_r < KW'(MAX_BASE)) && (char_k != '0);
    status.len_short  = (k_r < KW'(2));
    status.bad_char   = dup || (char_i == MINUS_CHAR) || (char_i == PLUS_CHAR);
    status.check_more = ((KW+1)'(i_r) + 1'b1) < (KW+1)'(k_r);
    status.div_more   = (cnt_r != DIV_CNT_W'(DIV_STEPS - 1));
    status.digit_more = (dq_r != '0) && (nd_r != DIGIT_CNT_W'(ALPHA_BYTES - 1));
    status.emit_more  = (nd_r != DIGIT_CNT_W'(1));
  end

  always_comb begin
    k_nxt             = k_r;
    i_nxt             = i_r;
    neg_nxt           = neg_r;
    dq_nxt            = dq_r;
    rem_nxt           = rem_r;
    cnt_nxt           = cnt_r;
    nd_nxt            = nd_r;
    out_strobe_nxt    = 1'b0;
    out_character_nxt = out_character_r;
    out_last_nxt      = out_last_r;
    unique case (ctrl.op)
      OP_LOAD: begin
        k_nxt   = '0;
        nd_nxt  = '0;
        neg_nxt = v_u[VALUE_W-1];
        dq_nxt  = mag;
      end
      OP_SCAN: begin
        if (status.scan_more) begin
          k_nxt = k_r + 1'b1;
        end
      end
      OP_CLRI: i_nxt = '0;
      OP_NOP: ;
      OP_INCI: i_nxt = i_r + 1'b1;
      OP_DIVINIT: begin
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      OP_DIV: begin
        rem_nxt = div_rem;
        dq_nxt  = div_q;
        cnt_nxt = cnt_r + 1'b1;
      end
      OP_STORE: nd_nxt = nd_r + 1'b1;
      OP_SIGN: begin
        out_strobe_nxt    = neg_r;
        out_character_nxt = MINUS_CHAR;
        out_last_nxt      = 1'b0;
      end
      OP_EMIT: begin
        out_strobe_nxt    = 1'b1;
        out_character_nxt = digit_r[rd_idx];
        out_last_nxt      = (nd_r == DIGIT_CNT_W'(1));
        nd_nxt            = nd_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r             <= k_nxt;
    i_r             <= i_nxt;
    neg_r           <= neg_nxt;
    dq_r            <= dq_nxt;
    rem_r           <= rem_nxt;
    cnt_r           <= cnt_nxt;
    nd_r            <= nd_nxt;
    out_character_r <= out_character_nxt;
    out_last_r      <= out_last_nxt;
    if (ctrl.op == OP_STORE) begin
      digit_r[DIGIT_IDX_W'(nd_r)] <= alpha_char(alpha, AIDX_W'(rem_r));
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

// ===== sv/signed_integer_to_base_digits.sv =====
// Top level: signed 32-bit value to text in a radix set by the alphabet registers.
// Busy is high while an item is in progress; a new value is taken only when the block is idle.
// An invalid alphabet ends the item with no characters.
// Characters follow one a cycle, a sign first for a negative value.
// One shared divider, eight quotient bits a cycle, sets the digit rate.
// Synchronous active-low reset returns the sequencer to idle and restores a decimal alphabet.
module signed_integer_to_base_digits #(
  parameter int unsigned MAX_BASE = sitbd_pkg::MAX_BASE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [sitbd_pkg::VALUE_W-1:0] in_value,
  output logic                                 busy,
  output logic                                 out_strobe,
  output logic [sitbd_pkg::CHAR_W-1:0]         out_character,
  output logic                                 out_last,
  input  logic                                 cfg_we,
  input  logic [sitbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sitbd_pkg::WORD_W-1:0]         cfg_data
);
  import sitbd_pkg::*;

  logic [ALPHA_W-1:0] alpha;
  ctrl_word_t         ctrl;
  dp_status_t         status;

  sitbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .alpha     (alpha)
  );

  sitbd_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  sitbd_dp #(
    .MAX_BASE (MAX_BASE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .in_value      (in_value),
    .alpha         (alpha),
    .status        (status),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

// ===== sv/sitbd_checker.sv =====
// Port-level checker for signed_integer_to_base_digits, attached by a bind statement.
// Depends on sitbd_pkg.
module sitbd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_strobe,
  input logic [sitbd_pkg::CHAR_W-1:0]   out_character,
  input logic                           out_last
);
  import sitbd_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("Accepted transfer did not make the block busy.");

  a_out_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("Result transfer without an item in progress.");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> !out_strobe)
    else $error("Result transfer directly after the final character.");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> !out_strobe)
    else $error("Result transfer as the block returned to idle.");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_character == MINUS_CHAR)) |-> !out_last)
    else $error("Sign character flagged as the final character.");

endmodule

bind signed_integer_to_base_digits sitbd_checker u_sitbd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_character (out_character),
  .out_last      (out_last)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for signed_integer_to_base_digits: drives values and alphabet writes
// and checks every character transfer against a predictor kept in step with the alphabet.
// Depends on sitbd_pkg and the block under test only.
module tb;
  import sitbd_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 360;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned DIR_ROWS       = 22;
  localparam int unsigned IDLE_PCT [3]   = '{0, 75, 25};
  localparam logic [CFG_IDX_W-1:0] SPARE_REG = 3'd4;
  localparam cfg_reg_t ALPHA_REGS [ALPHA_WORDS] = '{REG_ALPHA0, REG_ALPHA1, REG_ALPHA2,
                                                    REG_ALPHA3};

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  typedef struct {
    int unsigned sel;
    logic [31:0] value;
    string       text;
    bit          typed;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic signed [VALUE_W-1:0] in_value;
  logic                  busy;
  logic                  out_strobe;
  logic [CHAR_W-1:0]     out_character;
  logic                  out_last;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [WORD_W-1:0]     cfg_data;

  logic [ALPHA_W-1:0] alphabet_now;
  text_char_t         pending_chars [$];
  int unsigned        fault_count;
  int unsigned        quiet_cycles;

  logic [ALPHA_W-1:0] dir_alphabets [10] = '{
    {64'h0, 64'h0, 64'h0000_0000_0000_3938, 64'h3736_3534_3332_3130},
    {64'hFEDC_BA98_7654_3210, 64'h0, 64'h0123_4567_89AB_CDEF, 64'hFF80_7F5A_A500_3130},
    {64'h5655_5453_5251_504F, 64'h4E4D_4C4B_4A49_4847, 64'h4645_4443_4241_3938,
     64'h3736_3534_3332_3130},
    {64'h0, 64'h0, 64'h0, 64'h0000_0000_0041_FF80},
    {64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_0030},
    {64'h0, 64'h0, 64'h0, 64'h3132_3334_3536_3700},
    {64'h0, 64'h0, 64'h0, 64'h0000_0000_0000_2B30},
    {64'h0, 64'h0, 64'h0, 64'h0000_0000_0031_302D},
    {64'h0, 64'h0, 64'h0, 64'h0000_0000_3032_3130},
    {64'h3055_5453_5251_504F, 64'h4E4D_4C4B_4A49_4847, 64'h4645_4443_4241_3938,
     64'h3736_3534_3332_3130}
  };

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{0, 32'd0, "0", 1'b1},
    '{0, 32'd1, "1", 1'b1},
    '{0, 32'hFFFF_FFFF, "-1", 1'b1},
    '{0, 32'h7FFF_FFFF, "2147483647", 1'b1},
    '{0, 32'h8000_0000, "-2147483648", 1'b1},
    '{0, 32'd10, "", 1'b0},
    '{0, -32'sd907, "", 1'b0},
    '{1, 32'h8000_0000, "", 1'b0},
    '{1, 32'd5, "", 1'b0},
    '{1, 32'd0, "0", 1'b1},
    '{2, 32'h7FFF_FFFF, "", 1'b0},
    '{2, 32'h8000_0000, "", 1'b0},
    '{2, 32'd31, "V", 1'b1},
    '{2, -32'sd32, "", 1'b0},
    '{3, 32'd7, "", 1'b0},
    '{3, 32'hFFFF_FFFF, "", 1'b0},
    '{4, 32'd5, "", 1'b1},
    '{5, -32'sd5, "", 1'b1},
    '{6, 32'd3, "", 1'b1},
    '{7, -32'sd3, "", 1'b1},
    '{8, 32'd9, "", 1'b1},
    '{9, 32'd1, "", 1'b1}
  };

  signed_integer_to_base_digits uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_value      (in_value),
    .busy          (busy),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [CHAR_W-1:0] alpha_byte(int unsigned k);
    return alphabet_now[CHAR_W*k +: CHAR_W];
  endfunction

  function automatic int unsigned alphabet_radix();
    int unsigned len;
    len = 0;
    while (len < ALPHA_BYTES && alpha_byte(len) != 8'h00) len++;
    if (len < 2) return 0;
    for (int i = 0; i < len; i++) begin
      if (alpha_byte(i) == MINUS_CHAR || alpha_byte(i) == PLUS_CHAR) return 0;
      for (int j = i + 1; j < len; j++) begin
        if (alpha_byte(j) == alpha_byte(i)) return 0;
      end
    end
    return len;
  endfunction

  function automatic void spell_value(logic [31:0] v);
    logic [31:0]       mag;
    logic [CHAR_W-1:0] digits [$];
    int unsigned       radix;
    radix = alphabet_radix();
    if (radix == 0) return;
    mag = v[31] ? (~v + 32'd1) : v;
    do begin
      digits.push_front(alpha_byte(mag % radix));
      mag = mag / radix;
    end while (mag != 0);
    if (v[31]) pending_chars.push_back('{ch: MINUS_CHAR, last: 1'b0});
    foreach (digits[i]) begin
      pending_chars.push_back('{ch: digits[i], last: (i == digits.size() - 1)});
    end
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) begin
      pending_chars.push_back('{ch: s[i], last: (i == s.len() - 1)});
    end
  endfunction

  function automatic logic [ALPHA_W-1:0] random_alphabet(bit broken);
    logic [ALPHA_W-1:0] a;
    bit                 taken [256];
    int unsigned        len;
    int unsigned        pos;
    logic [CHAR_W-1:0]  c;
    for (int k = 0; k < ALPHA_W / 32; k++) a[32*k +: 32] = $urandom;
    case ($urandom_range(0, 3))
      0: len = $urandom_range(2, 4);
      1: len = ALPHA_BYTES;
      default: len = $urandom_range(2, ALPHA_BYTES);
    endcase
    if (broken && $urandom_range(0, 2) == 0) len = $urandom_range(0, 1);
    for (int k = 0; k < len; k++) begin
      do c = 8'($urandom_range(1, 255));
      while (taken[c] || c == MINUS_CHAR || c == PLUS_CHAR);
      taken[c] = 1'b1;
      a[CHAR_W*k +: CHAR_W] = c;
    end
    if (len < ALPHA_BYTES) a[CHAR_W*len +: CHAR_W] = 8'h00;
    if (broken && len >= 2) begin
      pos = $urandom_range(0, len - 1);
      case ($urandom_range(0, 2))
        0: a[CHAR_W*pos +: CHAR_W] = PLUS_CHAR;
        1: a[CHAR_W*pos +: CHAR_W] = MINUS_CHAR;
        default: a[CHAR_W*pos +: CHAR_W] = a[CHAR_W*((pos + 1) % len) +: CHAR_W];
      endcase
    end
    return a;
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7FFF_FFFF;
      2: v = 32'h0;
      3: v = -$urandom_range(1, 64);
      4: v = $urandom_range(1, 1000);
      5: begin
        v = $urandom >> $urandom_range(1, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic send_item(logic [31:0] v, bit typed, string text);
    @(negedge clk);
    start    <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (busy);
    if (typed) push_text(text);
    else spell_value(v);
  endtask

  task automatic idle_gap();
    int unsigned len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 8);
    repeat (len) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain_block();
    @(negedge clk);
    start <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_alphabet(logic [ALPHA_W-1:0] a);
    for (int i = 0; i < ALPHA_WORDS; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= ALPHA_REGS[i];
      cfg_data  <= a[WORD_W*i +: WORD_W];
      alphabet_now[WORD_W*i +: WORD_W] = a[WORD_W*i +: WORD_W];
    end
    // A write beyond the last alphabet word must leave the alphabet alone.
    @(negedge clk);
    cfg_index <= SPARE_REG | CFG_IDX_W'($urandom_range(0, 3));
    cfg_data  <= {$urandom, $urandom};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (out_strobe) begin
        if (pending_chars.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, got character %h last %0b",
                   $time, out_character, out_last);
          fault_count++;
        end else begin
          want = pending_chars.pop_front();
          if (out_character !== want.ch) begin
            $display("%0t: character mismatch: expected %h, got %h",
                     $time, want.ch, out_character);
            fault_count++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, want.last, out_last);
            fault_count++;
          end
        end
      end
      if (out_strobe || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    int unsigned cur_sel;
    int unsigned gap_pct;
    bit          broken;
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_value     = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_ALPHA0;
    cfg_data     = '0;
    fault_count  = 0;
    quiet_cycles = 0;
    alphabet_now = dir_alphabets[0];
    cur_sel      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].sel != cur_sel) begin
        drain_block();
        write_alphabet(dir_alphabets[dir_rows[r].sel]);
        cur_sel = dir_rows[r].sel;
      end
      send_item(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].text);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      broken  = (ph % 4 == 3);
      gap_pct = IDLE_PCT[ph % 3];
      drain_block();
      write_alphabet(random_alphabet(broken));
      for (int n = 0; n < (broken ? 3 : 12); n++) begin
        send_item(random_value(), 1'b0, "");
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) idle_gap();
        else if ((ph == 0 && n == 7) || $urandom_range(0, 29) == 0) drain_block();
      end
    end

    drain_block();
    if (fault_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
